// ===== design/assert_macros.svh =====
// Assertion macros for the cipher modules, used by the controller.
// Depends on nothing; included by files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// ===== design/aes_pkg.sv =====
// Package for the AES-256 CBC cipher: payload types, codes, S-box and round functions.
// Depends on nothing; used by the datapath, the controller and the top level.
`timescale 1ns / 1ps
package aes_pkg;
	localparam int unsigned NumRounds = 14;
	localparam int unsigned NumKeyWords = 60;
	localparam int unsigned BlockBytes = 16;

	typedef struct packed {
		logic [63:0] block_high;
		logic [63:0] block_low;
		logic        first_block;
		logic        message_end;
	} in_item_t;

	typedef struct packed {
		logic [63:0] result_high;
		logic [63:0] result_low;
		logic        message_end_out;
	} out_item_t;

	typedef enum logic [2:0] {
		REG_KEY0 = 3'd0, REG_KEY1 = 3'd1, REG_KEY2 = 3'd2, REG_KEY3 = 3'd3,
		REG_IV_HIGH = 3'd4, REG_IV_LOW = 3'd5, REG_MODE = 3'd6
	} reg_index_t;

	typedef enum logic [2:0] {
		ST_EXPAND, ST_IDLE, ST_LOAD, ST_ROUND, ST_FINISH, ST_OUT
	} ctrl_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       exp_start;
		logic       exp_step;
		logic [5:0] exp_idx;
		logic       load;
		logic       round;
		logic [3:0] rnd;
		logic       finish;
		logic       out_set;
		logic       out_clr;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_full;
	} dp_stat_t;

	function automatic logic [7:0] xt(input logic [7:0] a);
		xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] sbox(input logic [7:0] x);
		logic [7:0] t [256];
		t = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
		sbox = t[x];
	endfunction

	function automatic logic [7:0] inv_sbox(input logic [7:0] x);
		logic [7:0] t [256];
		t = '{
		8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
		8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
		8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
		8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
		8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
		8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
		8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
		8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
		8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
		8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
		8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
		8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
		8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
		8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
		8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
		inv_sbox = t[x];
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		sub_word = {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
	endfunction

	// Byte i of the state sits at bits [127-8i -: 8].
	function automatic logic [127:0] sub_shift(input logic [127:0] s, input logic inv);
		logic [127:0] t;
		t = '0;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				if (inv)
					t[127 - 8*(4*((c+r)&3)+r) -: 8] = inv_sbox(s[127 - 8*(4*c+r) -: 8]);
				else
					t[127 - 8*(4*c+r) -: 8] = sbox(s[127 - 8*(4*((c+r)&3)+r) -: 8]);
			end
		end
		sub_shift = t;
	endfunction

	function automatic logic [127:0] mix(input logic [127:0] s, input logic inv);
		logic [127:0] t;
		logic [7:0] a0, a1, a2, a3, b0, b1, b2, b3, u, v;
		t = '0;
		for (int c = 0; c < 4; c++) begin
			a0 = s[127 - 8*(4*c) -: 8];
			a1 = s[127 - 8*(4*c+1) -: 8];
			a2 = s[127 - 8*(4*c+2) -: 8];
			a3 = s[127 - 8*(4*c+3) -: 8];
			if (inv) begin
				// Inverse mix as a pre-multiply followed by the forward mix.
				u = xt(xt(a0 ^ a2));
				v = xt(xt(a1 ^ a3));
				a0 = a0 ^ u; a1 = a1 ^ v; a2 = a2 ^ u; a3 = a3 ^ v;
			end
			b0 = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
			b1 = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
			b2 = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
			b3 = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
			t[127 - 8*(4*c) -: 32] = {b0, b1, b2, b3};
		end
		mix = t;
	endfunction
endpackage

// ===== design/aes_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
module aes_ram #(
	parameter int Width = 32,
	parameter int Depth = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== design/aes_datapath.sv =====
// Datapath: key expansion, round-key memories, cipher state, chain value and output register.
// Depends on aes_pkg and aes_ram.
`timescale 1ns / 1ps
module aes_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [255:0]        key,
	input  logic [127:0]        iv,
	input  logic                enc,
	input  aes_pkg::in_item_t   in_item,
	input  aes_pkg::dp_cmd_t    cmd,
	output aes_pkg::dp_stat_t   stat,
	output aes_pkg::out_item_t  out_item
);
	import aes_pkg::*;

	logic [255:0] win_q;
	logic [7:0]   rcon_q;
	logic [127:0] state_q, chain_q, ct_q;
	logic         end_q, enc_q, full_q;
	logic [127:0] ostate_q;
	logic         oend_q;
	logic [127:0] rk;
	logic [31:0]  rk0, rk1, rk2, rk3, t_w, new_w;
	logic [3:0]   ridx;
	logic [3:0]   rnd_set;

	// Sliding window of the last eight key words produces one new word per step.
	always_comb begin
		t_w = win_q[31:0];
		if (cmd.exp_idx[2:0] == 3'd0)
			t_w = sub_word({t_w[23:0], t_w[31:24]}) ^ {rcon_q, 24'h0};
		else if (cmd.exp_idx[2:0] == 3'd4)
			t_w = sub_word(t_w);
		new_w = win_q[255:224] ^ t_w;
	end

	// The window holds the key itself until word 8; from then on it slides.
	always_ff @(posedge clk) begin
		if (cmd.exp_start) begin
			win_q  <= key;
			rcon_q <= 8'h01;
		end else if (cmd.exp_step && cmd.exp_idx >= 6'd8) begin
			win_q <= {win_q[223:0], new_w};
			if (cmd.exp_idx[2:0] == 3'd0)
				rcon_q <= xt(rcon_q);
		end
	end

	// Key word written at step i: words 0..7 come straight from the key.
	logic [31:0] exp_w;
	assign exp_w = (cmd.exp_idx < 6'd8) ? key[255 - 32*cmd.exp_idx[2:0] -: 32] : new_w;

	// Four column memories, each holding word 4r+c of every round key.
	assign rnd_set = cmd.rnd;
	assign ridx    = rnd_set;
	aes_ram #(.Width(32), .Depth(16)) u_rk0 (.clk, .we(cmd.exp_step && cmd.exp_idx[1:0] == 2'd0),
		.waddr(cmd.exp_idx[5:2]), .wdata(exp_w), .raddr(ridx), .rdata(rk0));
	aes_ram #(.Width(32), .Depth(16)) u_rk1 (.clk, .we(cmd.exp_step && cmd.exp_idx[1:0] == 2'd1),
		.waddr(cmd.exp_idx[5:2]), .wdata(exp_w), .raddr(ridx), .rdata(rk1));
	aes_ram #(.Width(32), .Depth(16)) u_rk2 (.clk, .we(cmd.exp_step && cmd.exp_idx[1:0] == 2'd2),
		.waddr(cmd.exp_idx[5:2]), .wdata(exp_w), .raddr(ridx), .rdata(rk2));
	aes_ram #(.Width(32), .Depth(16)) u_rk3 (.clk, .we(cmd.exp_step && cmd.exp_idx[1:0] == 2'd3),
		.waddr(cmd.exp_idx[5:2]), .wdata(exp_w), .raddr(ridx), .rdata(rk3));
	assign rk = {rk0, rk1, rk2, rk3};

	// Cipher state: load latches the block; round applies one round with the key read last cycle.
	logic [127:0] in_blk, chain_use, nxt;
	assign in_blk = {in_item.block_high, in_item.block_low};
	assign chain_use = in_item.first_block ? iv : chain_q;

	always_comb begin
		nxt = state_q;
		if (cmd.round) begin
			if (enc_q) begin
				nxt = mix(sub_shift(state_q, 1'b0), 1'b0) ^ rk;
			end else begin
				nxt = mix(sub_shift(state_q, 1'b1) ^ rk, 1'b1);
			end
		end else if (cmd.finish) begin
			nxt = sub_shift(state_q, ~enc_q) ^ rk;
		end
	end

	// The chain value is set at load and moves on when the output register is written.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q <= '0;
			full_q  <= 1'b0;
		end else begin
			if (cmd.load)
				chain_q <= chain_use;
			if (cmd.out_set)
				chain_q <= enc_q ? state_q : ct_q;
			if (cmd.out_set)
				full_q <= 1'b1;
			else if (cmd.out_clr)
				full_q <= 1'b0;
		end
	end

	// The first key addition follows the load as a separate stage, flagged by pend_q.
	logic pend_q;
	always_ff @(posedge clk) begin
		pend_q <= cmd.load;
		if (cmd.load) begin
			state_q <= enc ? (in_blk ^ chain_use) : in_blk;
			ct_q    <= in_blk;
			end_q   <= in_item.message_end;
			enc_q   <= enc;
		end else if (pend_q) begin
			state_q <= state_q ^ rk;
		end else begin
			state_q <= nxt;
		end
		if (cmd.out_set) begin
			ostate_q <= enc_q ? state_q : (state_q ^ chain_q);
			oend_q   <= end_q;
		end
	end

	assign stat.out_full = full_q;
	assign out_item.result_high     = ostate_q[127:64];
	assign out_item.result_low      = ostate_q[63:0];
	assign out_item.message_end_out = oend_q;
endmodule

// ===== design/aes_ctrl.sv =====
// Controller state machine: key expansion sequencing and round sequencing.
// Depends on aes_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module aes_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              key_wr,
	input  logic              enc,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              out_ready,
	input  aes_pkg::dp_stat_t stat,
	output aes_pkg::dp_cmd_t  cmd,
	output logic              out_valid
);
	import aes_pkg::*;

	ctrl_state_t state_q, state_d;
	logic [5:0]  idx_q;
	logic [3:0]  rnd_q;
	logic        enc_q;
	logic        restart_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_EXPAND: if (idx_q == 6'(NumKeyWords - 1)) state_d = ST_IDLE;
			ST_IDLE:   if (key_wr) state_d = ST_EXPAND;
			           else if (in_valid) state_d = ST_LOAD;
			ST_LOAD:   state_d = ST_ROUND;
			ST_ROUND:  if (rnd_q == 4'(NumRounds - 1) - 4'd0 && enc_q) state_d = ST_FINISH;
			           else if (rnd_q == 4'd1 && !enc_q) state_d = ST_FINISH;
			ST_FINISH: state_d = ST_OUT;
			ST_OUT:    if (!stat.out_full || out_ready) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Round-key set presented to the memory read port in the cycle before the key is used.
	logic [3:0] rd_set;
	always_comb begin
		case (state_q)
			ST_IDLE:  rd_set = enc ? 4'd0 : 4'(NumRounds);
			ST_LOAD:  rd_set = enc_q ? 4'd1 : 4'(NumRounds - 1);
			ST_ROUND: rd_set = enc_q ? rnd_q + 4'd1 : rnd_q - 4'd1;
			default:  rd_set = 4'd0;
		endcase
	end

	// Outputs.
	always_comb begin
		cmd = '0;
		cmd.exp_idx   = idx_q;
		cmd.exp_step  = (state_q == ST_EXPAND) && !restart_q;
		cmd.exp_start = restart_q;
		cmd.load      = (state_q == ST_IDLE) && in_valid && !key_wr;
		cmd.rnd       = rd_set;
		cmd.round     = (state_q == ST_ROUND);
		cmd.finish    = (state_q == ST_FINISH);
		cmd.out_set   = (state_q == ST_OUT) && (!stat.out_full || out_ready);
		cmd.out_clr   = out_ready;
		in_ready      = (state_q == ST_IDLE) && !key_wr;
		out_valid     = stat.out_full;
	end

	// Registers: state, expansion index, round counter, captured mode and restart flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_EXPAND;
			idx_q     <= '0;
			rnd_q     <= '0;
			enc_q     <= 1'b1;
			restart_q <= 1'b1;
		end else begin
			state_q   <= key_wr ? ST_EXPAND : state_d;
			restart_q <= key_wr;
			if (key_wr || restart_q)
				idx_q <= '0;
			else if (state_q == ST_EXPAND)
				idx_q <= idx_q + 6'd1;
			if (cmd.load) begin
				enc_q <= enc;
				rnd_q <= enc ? 4'd0 : 4'(NumRounds);
			end else if (state_q == ST_LOAD || state_q == ST_ROUND) begin
				rnd_q <= enc_q ? rnd_q + 4'd1 : rnd_q - 4'd1;
			end
		end
	end

	`ASSERT_IMPL(a_no_load_busy, clk, arst_n, cmd.load, state_q == ST_IDLE)
	`ASSERT_IMPL(a_step_in_expand, clk, arst_n, cmd.exp_step, state_q == ST_EXPAND)
	`ASSERT_NEXT(a_finish_then_out, clk, arst_n, cmd.finish && !key_wr, state_q == ST_OUT)
endmodule

// ===== design/aes256_cbc_cipher.sv =====
// Top level of the AES-256 CBC cipher: configuration registers, controller and datapath.
// Depends on aes_pkg, aes_ctrl and aes_datapath.
//
//  channel  | signals                         | direction
//  in       | in_valid, in_ready, in_item     | item in
//  out      | out_valid, out_ready, out_item  | item out
//  cfg      | cfg_we, cfg_index, cfg_data     | register write
//
// A result is valid once its item has been accepted and has passed key addition, 13 full
// rounds and the final round through one shared round unit, then the output register step.
// The next item is accepted only when the block is idle again after the output step.
// After reset, and after each key write, key expansion runs with in_ready low.
// A result waiting in the output register stalls the next item only at its output step.
`timescale 1ns / 1ps
module aes256_cbc_cipher (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  aes_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output aes_pkg::out_item_t out_item,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [63:0]        cfg_data
);
	import aes_pkg::*;

	logic [255:0] key_q;
	logic [127:0] iv_q;
	logic         enc_q;
	logic         key_wr;
	dp_cmd_t      cmd;
	dp_stat_t     stat;

	assign key_wr = cfg_we && (cfg_index == REG_KEY0 || cfg_index == REG_KEY1 ||
		cfg_index == REG_KEY2 || cfg_index == REG_KEY3);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
			iv_q  <= '0;
			enc_q <= 1'b1;
		end else if (cfg_we) begin
			case (reg_index_t'(cfg_index))
				REG_KEY0:    key_q[255:192] <= cfg_data;
				REG_KEY1:    key_q[191:128] <= cfg_data;
				REG_KEY2:    key_q[127:64]  <= cfg_data;
				REG_KEY3:    key_q[63:0]    <= cfg_data;
				REG_IV_HIGH: iv_q[127:64]   <= cfg_data;
				REG_IV_LOW:  iv_q[63:0]     <= cfg_data;
				REG_MODE:    enc_q          <= cfg_data[0];
				default:     ;
			endcase
		end
	end

	aes_ctrl u_ctrl (
		.clk, .arst_n, .key_wr, .enc(enc_q), .in_valid, .in_ready,
		.out_ready, .stat, .cmd, .out_valid
	);

	aes_datapath u_dp (
		.clk, .arst_n, .key(key_q), .iv(iv_q), .enc(enc_q), .in_item,
		.cmd, .stat, .out_item
	);
endmodule
